>>> rtl/stce_pkg.sv
// Shared constants and types for the sparse triangle count engine.
// Depends on nothing; stce_ctrl, stce_datapath and the top level import it.
`default_nettype none

package stce_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int MAX_ENTRIES  = 8192;

   // Field widths of the request and response words.
   localparam int OP_W    = 2;
   localparam int SLOT_W  = 14;
   localparam int VALUE_W = 14;
   localparam int COL_W   = 10;
   localparam int COUNT_W = 10;
   localparam int POS_W   = 13;
   localparam int TOTAL_W = 14;

   // Derived storage widths.
   localparam int PTR_DEPTH = MAX_VERTICES + 1;
   localparam int PTR_AW    = $clog2(PTR_DEPTH);
   localparam int VERT_W    = $clog2(MAX_VERTICES);
   localparam int ENTRY_AW  = $clog2(MAX_ENTRIES);
   localparam int PTR_W     = VALUE_W;
   localparam int ID_W      = VALUE_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [OP_W-1:0] OP_WRITE_PTR = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_NBR = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE   = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write_ptr;
      logic write_nbr;
      logic load;
      logic col_lo;
      logic col_hi;
      logic row_lo;
      logic row_hi;
      logic merge;
      logic publish;
   } ctl_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic empty;
      logic merge_done;
   } dp_status_type;

endpackage

`default_nettype wire

>>> rtl/stce_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module stce_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/stce_ctrl.sv
// Controller for the sparse triangle count engine: request decode and the
// sequencing of pointer fetches, the list merge and the response.
// Depends on stce_pkg.
`default_nettype none

module stce_ctrl
   import stce_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [OP_W-1:0]     req_operation,
   input  wire logic [SLOT_W-1:0]   req_slot,
   input  wire dp_status_type       status,
   output logic                     busy,
   output ctl_cmd_type              cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COL_LO,
      ST_COL_HI,
      ST_ROW_LO,
      ST_ROW_HI,
      ST_MERGE,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.write_ptr = accept && (req_operation == OP_WRITE_PTR)
                      && (req_slot <= SLOT_W'(MAX_VERTICES));
      cmd.write_nbr = accept && (req_operation == OP_WRITE_NBR)
                      && (req_slot < SLOT_W'(MAX_ENTRIES));
      cmd.load      = accept && (req_operation == OP_COMPUTE)
                      && (req_slot < SLOT_W'(MAX_ENTRIES));
      cmd.col_lo    = (state_ff == ST_COL_LO);
      cmd.col_hi    = (state_ff == ST_COL_HI);
      cmd.row_lo    = (state_ff == ST_ROW_LO);
      cmd.row_hi    = (state_ff == ST_ROW_HI);
      cmd.merge     = (state_ff == ST_MERGE);
      cmd.publish   = (state_ff == ST_FINISH);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_COL_LO;
            end
         end
         ST_COL_LO: state_in = ST_COL_HI;
         ST_COL_HI: state_in = ST_ROW_LO;
         ST_ROW_LO: state_in = ST_ROW_HI;
         ST_ROW_HI: begin
            state_in = status.empty ? ST_FINISH : ST_MERGE;
         end
         ST_MERGE: begin
            if (status.merge_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/stce_datapath.sv
// Datapath of the sparse triangle count engine: pointer and neighbour
// stores, list bounds, the two-pointer merge and the response registers.
// Depends on stce_pkg and stce_ram.
`default_nettype none

module stce_datapath
   import stce_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ctl_cmd_type         cmd,
   input  wire logic [SLOT_W-1:0]   req_slot,
   input  wire logic [VALUE_W-1:0]  req_value,
   input  wire logic [COL_W-1:0]    req_column,
   output dp_status_type            status,
   output logic                     rsp_valid,
   output logic [COUNT_W-1:0]       rsp_common_count,
   output logic [COL_W-1:0]         rsp_neighbor,
   output logic [POS_W-1:0]         rsp_entry_position,
   output logic [TOTAL_W-1:0]       rsp_nonzero_total
);

   // Request context.
   logic [POS_W-1:0]   slot_ff;
   logic [COL_W-1:0]   col_ff;
   logic [ID_W-1:0]    row_ff;

   // List bounds, ends already clamped to the entry limit.
   logic [PTR_W-1:0]   col_lo_ff, col_hi_ff, row_lo_ff, row_hi_ff;

   // Merge cursors and count.
   logic [PTR_W-1:0]   i_ff, j_ff, i_in, j_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [COL_W-1:0]   rsp_neighbor_ff;
   logic [POS_W-1:0]   rsp_entry_ff;

   logic [PTR_AW-1:0]   ptr_rd_addr;
   logic [PTR_W-1:0]    ptr_rd_data;
   logic [PTR_W-1:0]    ptr_clamped;
   logic [ENTRY_AW-1:0] nbr_addr_a, nbr_addr_b;
   logic [ID_W-1:0]     nbr_data_a, nbr_data_b;

   stce_ram #(.WIDTH(PTR_W), .DEPTH(PTR_DEPTH)) u_ptr_ram (
      .clock   (clock),
      .wr_en   (cmd.write_ptr),
      .wr_addr (req_slot[PTR_AW-1:0]),
      .wr_data (req_value),
      .rd_addr (ptr_rd_addr),
      .rd_data (ptr_rd_data)
   );

   // The neighbour store is held twice so that both lists are read each cycle.
   stce_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTRIES)) u_nbr_ram_a (
      .clock   (clock),
      .wr_en   (cmd.write_nbr),
      .wr_addr (req_slot[ENTRY_AW-1:0]),
      .wr_data (req_value),
      .rd_addr (nbr_addr_a),
      .rd_data (nbr_data_a)
   );

   stce_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTRIES)) u_nbr_ram_b (
      .clock   (clock),
      .wr_en   (cmd.write_nbr),
      .wr_addr (req_slot[ENTRY_AW-1:0]),
      .wr_data (req_value),
      .rd_addr (nbr_addr_b),
      .rd_data (nbr_data_b)
   );

   assign ptr_clamped = (ptr_rd_data > PTR_W'(MAX_ENTRIES)) ? PTR_W'(MAX_ENTRIES)
                                                            : ptr_rd_data;

   // Merge step: the cursor at the smaller id moves, both move on a match.
   always_comb begin
      i_in     = i_ff;
      j_in     = j_ff;
      count_in = count_ff;
      if (cmd.merge) begin
         if (nbr_data_a == nbr_data_b) begin
            i_in = i_ff + PTR_W'(1);
            j_in = j_ff + PTR_W'(1);
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end else if (nbr_data_a < nbr_data_b) begin
            i_in = i_ff + PTR_W'(1);
         end else begin
            j_in = j_ff + PTR_W'(1);
         end
      end
   end

   assign status.merge_done = (i_in >= col_hi_ff) || (j_in >= row_hi_ff);
   assign status.empty      = (row_ff >= ID_W'(MAX_VERTICES))
                              || (col_lo_ff >= col_hi_ff)
                              || (row_lo_ff >= ptr_clamped);

   // Pointer store address: column start, column end, row start, row end.
   always_comb begin
      if (cmd.load) begin
         ptr_rd_addr = PTR_AW'(req_column);
      end else if (cmd.col_lo) begin
         ptr_rd_addr = PTR_AW'(col_ff) + PTR_AW'(1);
      end else if (cmd.col_hi) begin
         ptr_rd_addr = PTR_AW'(row_ff[VERT_W-1:0]);
      end else begin
         ptr_rd_addr = PTR_AW'(row_ff[VERT_W-1:0]) + PTR_AW'(1);
      end
   end

   // Neighbour store addresses follow the next cursor values so that the
   // merge compares one pair every cycle.
   always_comb begin
      if (cmd.load) begin
         nbr_addr_a = req_slot[ENTRY_AW-1:0];
         nbr_addr_b = req_slot[ENTRY_AW-1:0];
      end else if (cmd.row_hi) begin
         nbr_addr_a = col_lo_ff[ENTRY_AW-1:0];
         nbr_addr_b = row_lo_ff[ENTRY_AW-1:0];
      end else begin
         nbr_addr_a = i_in[ENTRY_AW-1:0];
         nbr_addr_b = j_in[ENTRY_AW-1:0];
      end
   end

   always_comb begin
      total_in = total_ff;
      if (cmd.publish && (count_ff != '0) && (total_ff < TOTAL_W'(MAX_ENTRIES))) begin
         total_in = total_ff + TOTAL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         slot_ff <= req_slot[POS_W-1:0];
         col_ff  <= req_column;
      end
      if (cmd.col_lo) begin
         col_lo_ff <= ptr_rd_data;
         row_ff    <= nbr_data_a;
      end
      if (cmd.col_hi) begin
         col_hi_ff <= ptr_clamped;
      end
      if (cmd.row_lo) begin
         row_lo_ff <= ptr_rd_data;
      end
      if (cmd.row_hi) begin
         row_hi_ff <= ptr_clamped;
         i_ff      <= col_lo_ff;
         j_ff      <= row_lo_ff;
         count_ff  <= '0;
      end else begin
         i_ff     <= i_in;
         j_ff     <= j_in;
         count_ff <= count_in;
      end
      if (cmd.publish) begin
         rsp_count_ff    <= count_ff;
         rsp_neighbor_ff <= row_ff[COL_W-1:0];
         rsp_entry_ff    <= slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         rsp_valid_ff <= cmd.publish;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_common_count   = rsp_count_ff;
   assign rsp_neighbor       = rsp_neighbor_ff;
   assign rsp_entry_position = rsp_entry_ff;
   assign rsp_nonzero_total  = total_ff;

endmodule

`default_nettype wire

>>> rtl/sparse_triangle_count_engine.sv
// Sparse triangle count engine, top level. A write word leaves busy low.
// A compute word holds busy through the pointer fetches and k merge steps (at most the sum
// of the two list lengths less one, one id pair compared per cycle through the
// dual-read neighbour store); its response strobe is registered from the finish state and rises as busy falls.
// Synchronous active-high reset clears the controller, the strobe and the nonzero count;
// the stores are undefined until written. Depends on stce_pkg, stce_ctrl, stce_datapath.
`default_nettype none

module sparse_triangle_count_engine
   import stce_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [OP_W-1:0]     req_operation,
   input  wire logic [SLOT_W-1:0]   req_slot,
   input  wire logic [VALUE_W-1:0]  req_value,
   input  wire logic [COL_W-1:0]    req_column,
   output logic                     rsp_valid,
   output logic [COUNT_W-1:0]       rsp_common_count,
   output logic [COL_W-1:0]         rsp_neighbor,
   output logic [POS_W-1:0]         rsp_entry_position,
   output logic [TOTAL_W-1:0]       rsp_nonzero_total
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   stce_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .req_slot      (req_slot),
      .status        (status),
      .busy          (busy),
      .cmd           (cmd)
   );

   stce_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_slot           (req_slot),
      .req_value          (req_value),
      .req_column         (req_column),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_common_count   (rsp_common_count),
      .rsp_neighbor       (rsp_neighbor),
      .rsp_entry_position (rsp_entry_position),
      .rsp_nonzero_total  (rsp_nonzero_total)
   );

   // A compute word in range always starts a sequence.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == OP_COMPUTE)
       && (req_slot < SLOT_W'(MAX_ENTRIES))) |=> busy)
      else $error("compute word accepted without starting a sequence");

   // The response appears only just after a sequence ends, never while busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("response strobe outside the end of a sequence");

   // The response strobe is a single-cycle pulse.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // The nonzero count never passes its saturation limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_nonzero_total <= TOTAL_W'(MAX_ENTRIES))
      else $error("nonzero count beyond its limit");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the sparse triangle count engine: loads graphs in compressed-column
// form, computes masked common-neighbour counts and checks each response against a predictor.
// Depends on stce_pkg and sparse_triangle_count_engine.

module testbench;
   import stce_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 100000;
   localparam int WORDS_PER_PHASE = 350;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [COL_W-1:0]   neighbor;
      logic [POS_W-1:0]   pos;
      logic [TOTAL_W-1:0] total;
   } tally_type;

   localparam tally_type NO_TALLY = '0;

   typedef struct {
      logic [OP_W-1:0] op;
      int              slot;
      int              value;
      int              column;
      bit              typed;
      tally_type       tally;
   } step_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_operation = '0;
   logic [SLOT_W-1:0]   req_slot = '0;
   logic [VALUE_W-1:0]  req_value = '0;
   logic [COL_W-1:0]    req_column = '0;
   logic                rsp_valid;
   logic [COUNT_W-1:0]  rsp_common_count;
   logic [COL_W-1:0]    rsp_neighbor;
   logic [POS_W-1:0]    rsp_entry_position;
   logic [TOTAL_W-1:0]  rsp_nonzero_total;

   // Predictor copy of the two stores, with a record of which entries were ever written.
   logic [PTR_W-1:0] start_mem [0:PTR_DEPTH-1];
   bit               start_known [0:PTR_DEPTH-1];
   logic [ID_W-1:0]  id_mem [0:MAX_ENTRIES-1];
   bit               id_known [0:MAX_ENTRIES-1];
   int unsigned      nonzero_model = 0;

   tally_type pending_tallies [$];
   step_type  script [25];

   int sender_idle_pct = 0;
   int words_accepted = 0;
   int useful_words = 0;
   int responses_checked = 0;
   int max_common_seen = 0;
   int fail_count = 0;

   sparse_triangle_count_engine dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_slot           (req_slot),
      .req_value          (req_value),
      .req_column         (req_column),
      .rsp_valid          (rsp_valid),
      .rsp_common_count   (rsp_common_count),
      .rsp_neighbor       (rsp_neighbor),
      .rsp_entry_position (rsp_entry_position),
      .rsp_nonzero_total  (rsp_nonzero_total)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Bounds of a vertex's neighbour list, end clamped to the entry limit.
   function automatic bit list_span(input int v, output int lo, output int hi);
      lo = 0;
      hi = 0;
      if (v >= MAX_VERTICES) return 1'b0;
      lo = int'(start_mem[v]);
      hi = int'(start_mem[v + 1]);
      if (hi > MAX_ENTRIES) hi = MAX_ENTRIES;
      return lo < hi;
   endfunction

   function automatic int shared_neighbours(input int col, input int row);
      int i, ie, j, je, count;
      count = 0;
      if (!list_span(col, i, ie) || !list_span(row, j, je)) return 0;
      while (i < ie && j < je) begin
         if (id_mem[i] == id_mem[j]) begin
            if (count < int'(COUNT_MAX)) count++;
            i++;
            j++;
         end else if (id_mem[i] < id_mem[j]) begin
            i++;
         end else begin
            j++;
         end
      end
      return count;
   endfunction

   // Applies one accepted word to the predictor; returns 1 when a response is due.
   function automatic bit absorb_word(input logic [OP_W-1:0] op, input int slot,
                                      input int value, input int column,
                                      output tally_type t);
      int row, count;
      t = NO_TALLY;
      if (op == OP_WRITE_PTR) begin
         if (slot <= MAX_VERTICES) begin
            start_mem[slot] = value[PTR_W-1:0];
            start_known[slot] = 1'b1;
         end
         return 1'b0;
      end
      if (op == OP_WRITE_NBR) begin
         if (slot < MAX_ENTRIES) begin
            id_mem[slot] = value[ID_W-1:0];
            id_known[slot] = 1'b1;
         end
         return 1'b0;
      end
      if (op != OP_COMPUTE || slot >= MAX_ENTRIES) return 1'b0;
      row = int'(id_mem[slot]);
      count = shared_neighbours(column, row);
      if (count != 0 && nonzero_model < MAX_ENTRIES) nonzero_model++;
      t.count = count[COUNT_W-1:0];
      t.neighbor = row[COL_W-1:0];
      t.pos = slot[POS_W-1:0];
      t.total = nonzero_model[TOTAL_W-1:0];
      return 1'b1;
   endfunction

   function automatic bit span_known(input int v);
      int lo, hi;
      if (!start_known[v] || !start_known[v + 1]) return 1'b0;
      if (!list_span(v, lo, hi)) return 1'b1;
      for (int i = lo; i < hi; i++)
         if (!id_known[i]) return 1'b0;
      return 1'b1;
   endfunction

   // A compute word is only sent when every store entry it reads has been written.
   function automatic bit word_is_safe(input logic [OP_W-1:0] op, input int slot,
                                       input int column);
      int row;
      if (op != OP_COMPUTE || slot >= MAX_ENTRIES) return 1'b1;
      if (!id_known[slot]) return 1'b0;
      row = int'(id_mem[slot]);
      if (!span_known(column)) return 1'b0;
      return row >= MAX_VERTICES || span_known(row);
   endfunction

   function automatic bit word_is_ignored(input logic [OP_W-1:0] op, input int slot);
      if (op == OP_WRITE_PTR) return slot > MAX_VERTICES;
      if (op == OP_WRITE_NBR || op == OP_COMPUTE) return slot >= MAX_ENTRIES;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      fail_count++;
      if (fail_count <= 100)
         $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
   endtask

   task automatic send_word(input logic [OP_W-1:0] op, input int slot, input int value,
                            input int column);
      tally_type t;
      if (!word_is_safe(op, slot, column)) return;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_slot <= slot[SLOT_W-1:0];
      req_value <= value[VALUE_W-1:0];
      req_column <= column[COL_W-1:0];
      @(posedge clock);
      while (busy) @(posedge clock);
      words_accepted++;
      if (!word_is_ignored(op, slot)) useful_words++;
      if (absorb_word(op, slot, value, column, t)) pending_tallies.push_back(t);
   endtask

   task automatic send_noise();
      int slot;
      slot = $urandom_range(0, 1) ? $urandom_range(0, 16383) : $urandom_range(0, 1100);
      send_word(OP_W'($urandom_range(0, 3)), slot, $urandom_range(0, 16383),
                $urandom_range(0, 1023));
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_tallies.size() != 0) @(posedge clock);
   endtask

   // Loads a random symmetric graph, sometimes damages it, then computes over its entries.
   task automatic run_graph_episode();
      int n, p, v_base, e_base, total, sel, idx, owner, col, value;
      bit clamp;
      bit adj [0:63][0:63];
      int off [0:64];
      int ids [$];
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 24) : $urandom_range(2, 12);
      p = $urandom_range(15, 90);
      sel = $urandom_range(0, 3);
      v_base = (sel == 0) ? 0 : (sel == 1) ? MAX_VERTICES - n : $urandom_range(0, MAX_VERTICES - n);
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++)
            if (j > i) adj[i][j] = ($urandom_range(0, 99) < p);
            else if (j < i) adj[i][j] = adj[j][i];
            else adj[i][j] = 1'b0;
      off[0] = 0;
      for (int k = 0; k < n; k++) begin
         for (int j = 0; j < n; j++)
            if (adj[k][j]) ids.push_back(v_base + j);
         off[k + 1] = ids.size();
      end
      total = ids.size();
      sel = $urandom_range(0, 3);
      e_base = (sel == 0) ? 0 : (sel == 1) ? MAX_ENTRIES - total
                                           : $urandom_range(0, MAX_ENTRIES - total);
      // A list that ends on the last entry may carry an end pointer past the store.
      clamp = (sel == 1) && $urandom_range(0, 1);
      for (int k = 0; k <= n; k++) begin
         value = e_base + off[k];
         if (k == n && clamp) value = $urandom_range(MAX_ENTRIES, 16383);
         send_word(OP_WRITE_PTR, v_base + k, value, $urandom_range(0, 1023));
      end
      for (int i = 0; i < total; i++)
         send_word(OP_WRITE_NBR, e_base + i, ids[i], $urandom_range(0, 1023));
      // Damage: unsorted or duplicate ids, ids out of range, and crossed pointers.
      if ($urandom_range(0, 3) == 0 && total > 0) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 2))
               0: send_word(OP_WRITE_NBR, e_base + $urandom_range(0, total - 1),
                            v_base + $urandom_range(0, n - 1), 0);
               1: send_word(OP_WRITE_NBR, e_base + $urandom_range(0, total - 1),
                            $urandom_range(0, 16383), 0);
               default: send_word(OP_WRITE_PTR, v_base + $urandom_range(0, n),
                                  e_base + $urandom_range(0, total), 0);
            endcase
         end
      end
      if (total == 0) return;
      repeat ($urandom_range(n, 3 * n)) begin
         if ($urandom_range(0, 7) == 0) begin
            send_noise();
         end else begin
            idx = $urandom_range(0, total - 1);
            owner = 0;
            for (int k = 0; k < n; k++)
               if (idx >= off[k] && idx < off[k + 1]) owner = k;
            col = ($urandom_range(0, 4) == 0) ? v_base + $urandom_range(0, n - 1)
                                              : v_base + owner;
            send_word(OP_COMPUTE, e_base + idx, $urandom_range(0, 16383), col);
         end
      end
   endtask

   always @(posedge clock) begin : response_check
      tally_type want;
      if (!reset && rsp_valid) begin
         responses_checked++;
         if (int'(rsp_common_count) > max_common_seen) max_common_seen = rsp_common_count;
         if (pending_tallies.size() == 0) begin
            report_mismatch("response with nothing pending, position", rsp_entry_position, -1);
         end else begin
            want = pending_tallies.pop_front();
            if (rsp_common_count !== want.count)
               report_mismatch("common_count", rsp_common_count, want.count);
            if (rsp_neighbor !== want.neighbor)
               report_mismatch("neighbor", rsp_neighbor, want.neighbor);
            if (rsp_entry_position !== want.pos)
               report_mismatch("entry_position", rsp_entry_position, want.pos);
            if (rsp_nonzero_total !== want.total)
               report_mismatch("nonzero_total", rsp_nonzero_total, want.total);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) quiet = 0;
         else quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int idle_pct [3];
      int target;
      idle_pct = '{17, 81, 0};

      // Directed words: empty lists, extreme slots and ids, ignored words, a triangle,
      // a crossed pointer pair and an unsorted list with duplicates.
      script[0]  = '{OP_WRITE_PTR, 0, 0, 0, 1'b0, NO_TALLY};
      script[1]  = '{OP_WRITE_PTR, 1, 0, 0, 1'b0, NO_TALLY};
      script[2]  = '{OP_WRITE_NBR, 0, 0, 0, 1'b0, NO_TALLY};
      script[3]  = '{OP_COMPUTE, 0, 0, 0, 1'b1, NO_TALLY};
      script[4]  = '{OP_WRITE_PTR, 1023, 8192, 0, 1'b0, NO_TALLY};
      script[5]  = '{OP_WRITE_PTR, 1024, 16383, 1023, 1'b0, NO_TALLY};
      script[6]  = '{OP_WRITE_NBR, 8191, 16383, 1023, 1'b0, NO_TALLY};
      script[7]  = '{OP_COMPUTE, 8191, 16383, 1023, 1'b1,
                     '{count: 0, neighbor: 1023, pos: 8191, total: 0}};
      script[8]  = '{OP_WRITE_PTR, 1025, 5, 0, 1'b0, NO_TALLY};
      script[9]  = '{OP_WRITE_NBR, 8192, 5, 0, 1'b0, NO_TALLY};
      script[10] = '{OP_COMPUTE, 16383, 16383, 1023, 1'b0, NO_TALLY};
      script[11] = '{OP_UNUSED, 100, 100, 100, 1'b0, NO_TALLY};
      script[12] = '{OP_WRITE_PTR, 2, 2, 0, 1'b0, NO_TALLY};
      script[13] = '{OP_WRITE_PTR, 3, 4, 0, 1'b0, NO_TALLY};
      script[14] = '{OP_WRITE_PTR, 4, 6, 0, 1'b0, NO_TALLY};
      script[15] = '{OP_WRITE_NBR, 0, 2, 0, 1'b0, NO_TALLY};
      script[16] = '{OP_WRITE_NBR, 1, 3, 0, 1'b0, NO_TALLY};
      script[17] = '{OP_WRITE_NBR, 2, 1, 0, 1'b0, NO_TALLY};
      script[18] = '{OP_WRITE_NBR, 3, 3, 0, 1'b0, NO_TALLY};
      script[19] = '{OP_WRITE_NBR, 4, 1, 0, 1'b0, NO_TALLY};
      script[20] = '{OP_WRITE_NBR, 5, 2, 0, 1'b0, NO_TALLY};
      script[21] = '{OP_COMPUTE, 0, 0, 1, 1'b0, NO_TALLY};
      script[22] = '{OP_COMPUTE, 3, 0, 2, 1'b0, NO_TALLY};
      script[23] = '{OP_WRITE_PTR, 3, 1, 0, 1'b0, NO_TALLY};
      script[24] = '{OP_COMPUTE, 4, 0, 3, 1'b0, NO_TALLY};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = idle_pct[0];
      for (int i = 0; i < 25; i++) begin
         send_word(script[i].op, script[i].slot, script[i].value, script[i].column);
         if (script[i].typed) pending_tallies[pending_tallies.size() - 1] = script[i].tally;
      end
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         sender_idle_pct = idle_pct[ph];
         target = useful_words + WORDS_PER_PHASE;
         while (useful_words < target) run_graph_episode();
         // Hold the sender off until the block has returned everything outstanding.
         drain();
      end
      repeat (64) @(posedge clock);

      $display("Run covered %0d accepted words and %0d checked responses.",
               words_accepted, responses_checked);
      $display("Largest common count seen %0d; nonzero total reached %0d.",
               max_common_seen, nonzero_model);
      if (fail_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

>>> sparse_triangle_count_engine.f
rtl/stce_pkg.sv
rtl/stce_ram.sv
rtl/stce_ctrl.sv
rtl/stce_datapath.sv
rtl/sparse_triangle_count_engine.sv
bench/testbench.sv
